/* src/fwevg_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed-weight error vector generator package
// Shared constants, command and status codes, and the beat types of the
// request and response channels.
// ----------------------------------------------------------------------------
package fwevg_pkg;

	// Sizing of the vector store and the attempt rules.
	localparam int unsigned STORE_WORDS   = 128;
	localparam int unsigned MAX_WEIGHT    = 128;
	localparam int unsigned ATTEMPT_LIMIT = 203;
	localparam int unsigned VEC_WIDTH     = 64;
	localparam int unsigned ADDR_W        = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
	localparam int unsigned VEC_BITS      = STORE_WORDS * VEC_WIDTH;

	// Configuration register widths.
	localparam int unsigned CFG_DATA_W  = 14;
	localparam int unsigned CFG_INDEX_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_FIELD_BITS  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CODE_LENGTH = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ERROR_WEIGHT = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_WORDS_PER_ATTEMPT = 2'd3;

	// Configuration reset values.
	localparam logic [3:0]  RST_FIELD_BITS  = 4'd12;
	localparam logic [13:0] RST_CODE_LENGTH = 14'd3488;
	localparam logic [7:0]  RST_ERROR_WEIGHT = 8'd64;
	localparam logic [8:0]  RST_WORDS_PER_ATTEMPT = 9'd128;

	// Request commands.
	localparam logic CMD_FEED = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// Response status codes.
	localparam logic [1:0] ST_COLLECT = 2'd0;
	localparam logic [1:0] ST_READY   = 2'd1;
	localparam logic [1:0] ST_REJECT  = 2'd2;
	localparam logic [1:0] ST_EXHAUST = 2'd3;

	typedef struct packed {
		logic        cmd;
		logic [15:0] rand_word;
		logic [6:0]  read_index;
	} req_beat_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [VEC_WIDTH-1:0] vector_word;
	} rsp_beat_t;

endpackage
`default_nettype wire

/* src/fwevg_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; a read at the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
module fwevg_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 128
) (
	input  wire logic                                        clk,
	input  wire logic                                        we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                            wdata,
	input  wire logic                                        re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

/* src/fixed_weight_error_vector_gen.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed-weight error vector generator
// Collects error positions from random words into a bit vector held in RAM,
// checks weight and distinctness at the end of each attempt, and serves
// 64-bit reads of the finished vector.
// ----------------------------------------------------------------------------
// Path: a request beat is captured in stage one, then in the output register
// once that is free or being emptied. Throughput: one request beat per cycle
// while the output keeps up; a feed reads its vector word at accept time and
// writes it back as it leaves stage one, with a bypass from the last write.
// Reset: configuration takes its defaults, all counts clear, and every vector
// word is marked empty by its flag, so the store reads as zero at once.

module fixed_weight_error_vector_gen (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 req_valid,
	output logic                                      req_ready,
	input  wire fwevg_pkg::req_beat_t                 req_data,
	output logic                                      rsp_valid,
	input  wire logic                                 rsp_ready,
	output fwevg_pkg::rsp_beat_t                      rsp_data,
	input  wire logic                                 cfg_we,
	input  wire logic [fwevg_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [fwevg_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int unsigned AW = fwevg_pkg::ADDR_W;
	localparam int unsigned VW = fwevg_pkg::VEC_WIDTH;

	// Configuration registers.
	logic [3:0]  field_bits_q;
	logic [13:0] code_length_q;
	logic [7:0]  error_weight_q;
	logic [8:0]  words_per_attempt_q;

	// Attempt state.
	logic [7:0]                        accepted_count_q;
	logic [8:0]                        word_count_q;
	logic                              duplicate_seen_q;
	logic [7:0]                        attempt_count_q;
	logic                              vector_ready_q;
	logic [fwevg_pkg::STORE_WORDS-1:0] word_valid_q;
	logic [fwevg_pkg::STORE_WORDS-1:0] word_valid_next;

	// Stage one registers.
	logic          valid_s1;
	logic          cmd_s1;
	logic [15:0]   pos_s1;
	logic [AW-1:0] read_addr_s1;
	logic          read_ok_s1;

	// Last RAM write, for the bypass.
	logic          wr_valid_q;
	logic [AW-1:0] wr_addr_q;
	logic [VW-1:0] wr_data_q;

	// Output register.
	logic                 rsp_valid_q;
	fwevg_pkg::rsp_beat_t rsp_data_q;

	logic          req_fire;
	logic          advance;
	logic [15:0]   pos_mask;
	logic [15:0]   pos_in;
	logic [AW-1:0] ram_raddr;
	logic [VW-1:0] ram_rdata;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [VW-1:0] ram_wdata;

	logic [13:0]   limit;
	logic [7:0]    weight_eff;
	logic [8:0]    tau_eff;
	logic          exhausted;
	logic          restart;
	logic [AW-1:0] addr_s1;
	logic [VW-1:0] stored_word;
	logic [VW-1:0] old_word;
	logic [VW-1:0] pos_bit;
	logic [7:0]    acc_base;
	logic [8:0]    wc_base;
	logic          dup_base;
	logic [7:0]    att_base;
	logic          take;
	logic [7:0]    acc_next;
	logic [8:0]    wc_next;
	logic          dup_next;
	logic [7:0]    att_inc;
	logic          attempt_end;
	logic          attempt_ok;
	fwevg_pkg::rsp_beat_t rsp_next;

	// Handshake: stage one moves on whenever the output register is free or being emptied.
	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign req_fire  = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

	// Position from the random word, and the RAM read address at accept time.
	assign pos_mask = 16'((17'd1 << field_bits_q) - 17'd1);
	assign pos_in   = req_data.rand_word & pos_mask;
	assign ram_raddr = (req_data.cmd == fwevg_pkg::CMD_READ) ?
		req_data.read_index[AW-1:0] : pos_in[6 +: AW];

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_bits_q        <= fwevg_pkg::RST_FIELD_BITS;
			code_length_q       <= fwevg_pkg::RST_CODE_LENGTH;
			error_weight_q      <= fwevg_pkg::RST_ERROR_WEIGHT;
			words_per_attempt_q <= fwevg_pkg::RST_WORDS_PER_ATTEMPT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fwevg_pkg::REG_FIELD_BITS: begin
					field_bits_q <= cfg_data[3:0];
				end
				fwevg_pkg::REG_CODE_LENGTH: begin
					code_length_q <= cfg_data[13:0];
				end
				fwevg_pkg::REG_ERROR_WEIGHT: begin
					error_weight_q <= cfg_data[7:0];
				end
				fwevg_pkg::REG_WORDS_PER_ATTEMPT: begin
					words_per_attempt_q <= cfg_data[8:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Stage one: capture the request beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_s1       <= req_data.cmd;
			pos_s1       <= pos_in;
			read_addr_s1 <= req_data.read_index[AW-1:0];
			read_ok_s1   <= ({1'b0, req_data.read_index} < 8'(fwevg_pkg::STORE_WORDS));
		end
	end

	// Effective attempt parameters.
	always_comb begin
		limit = {code_length_q[13:3], 3'b000};
		if (limit > 14'(fwevg_pkg::VEC_BITS)) begin
			limit = 14'(fwevg_pkg::VEC_BITS);
		end
		weight_eff = (error_weight_q > 8'(fwevg_pkg::MAX_WEIGHT)) ?
			8'(fwevg_pkg::MAX_WEIGHT) : error_weight_q;
		tau_eff = (words_per_attempt_q == 9'd0) ? 9'd1 : words_per_attempt_q;
	end

	assign exhausted = (attempt_count_q >= 8'(fwevg_pkg::ATTEMPT_LIMIT));

	// Current contents of the addressed word, with bypass and empty flag.
	assign addr_s1 = (cmd_s1 == fwevg_pkg::CMD_READ) ? read_addr_s1 : pos_s1[6 +: AW];
	always_comb begin
		if (!word_valid_q[addr_s1]) begin
			stored_word = '0;
		end else if (wr_valid_q && (wr_addr_q == addr_s1)) begin
			stored_word = wr_data_q;
		end else begin
			stored_word = ram_rdata;
		end
	end

	// Feed step: start over if needed, place the position, close the attempt.
	always_comb begin
		restart  = vector_ready_q || exhausted;
		acc_base = restart ? 8'd0 : accepted_count_q;
		wc_base  = restart ? 9'd0 : word_count_q;
		dup_base = restart ? 1'b0 : duplicate_seen_q;
		att_base = restart ? 8'd0 : attempt_count_q;
		old_word = restart ? '0 : stored_word;
		pos_bit  = VW'(1) << pos_s1[5:0];
		take     = ({2'b00, limit} > pos_s1) && (acc_base < weight_eff);
		acc_next = acc_base + 8'(take);
		dup_next = dup_base || (take && ((old_word & pos_bit) != '0));
		wc_next  = wc_base + 9'd1;
		att_inc  = att_base + 8'd1;
		attempt_end = (wc_next >= tau_eff);
		attempt_ok  = (acc_next >= weight_eff) && !dup_next;
	end

	// RAM write for an accepted position.
	assign ram_we    = advance && (cmd_s1 == fwevg_pkg::CMD_FEED) && take;
	assign ram_waddr = pos_s1[6 +: AW];
	assign ram_wdata = old_word | pos_bit;

	// Empty flags after this feed: all cleared on a fresh start, and the
	// flag of the written word set.
	always_comb begin
		word_valid_next = restart ? '0 : word_valid_q;
		if (take) begin
			word_valid_next[ram_waddr] = 1'b1;
		end
	end

	// Response for the beat in stage one.
	always_comb begin
		rsp_next.status      = fwevg_pkg::ST_COLLECT;
		rsp_next.vector_word = '0;
		if (cmd_s1 == fwevg_pkg::CMD_READ) begin
			if (vector_ready_q) begin
				rsp_next.status = fwevg_pkg::ST_READY;
				if (read_ok_s1) begin
					rsp_next.vector_word = stored_word;
				end
			end else if (exhausted) begin
				rsp_next.status = fwevg_pkg::ST_EXHAUST;
			end
		end else if (attempt_end) begin
			if (attempt_ok) begin
				rsp_next.status = fwevg_pkg::ST_READY;
			end else if (att_inc >= 8'(fwevg_pkg::ATTEMPT_LIMIT)) begin
				rsp_next.status = fwevg_pkg::ST_EXHAUST;
			end else begin
				rsp_next.status = fwevg_pkg::ST_REJECT;
			end
		end
	end

	// Attempt state update on each feed beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepted_count_q <= '0;
			word_count_q     <= '0;
			duplicate_seen_q <= 1'b0;
			attempt_count_q  <= '0;
			vector_ready_q   <= 1'b0;
			word_valid_q     <= '0;
		end else if (advance && (cmd_s1 == fwevg_pkg::CMD_FEED)) begin
			if (attempt_end && !attempt_ok) begin
				accepted_count_q <= '0;
				word_count_q     <= '0;
				duplicate_seen_q <= 1'b0;
				attempt_count_q  <= att_inc;
				vector_ready_q   <= 1'b0;
				word_valid_q     <= '0;
			end else begin
				accepted_count_q <= acc_next;
				word_count_q     <= attempt_end ? 9'd0 : wc_next;
				duplicate_seen_q <= dup_next;
				attempt_count_q  <= att_base;
				vector_ready_q   <= attempt_end;
				word_valid_q     <= word_valid_next;
			end
		end
	end

	// Last write, kept for the read issued at the same edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_q <= 1'b0;
		end else if (ram_we) begin
			wr_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			wr_addr_q <= ram_waddr;
			wr_data_q <= ram_wdata;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_data_q <= rsp_next;
		end
	end

	// Vector store.
	fwevg_ram #(
		.WIDTH(VW),
		.DEPTH(fwevg_pkg::STORE_WORDS)
	) u_vec_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (req_fire),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// The accepted count never passes the weight cap.
	a_acc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		accepted_count_q <= 8'(fwevg_pkg::MAX_WEIGHT))
		else $error("accepted count above weight cap");

	// The attempt count stops at the limit.
	a_att_bound: assert property (@(posedge clk) disable iff (!arst_n)
		attempt_count_q <= 8'(fwevg_pkg::ATTEMPT_LIMIT))
		else $error("attempt count above limit");

	// A finished vector always leaves the word count at zero.
	a_ready_wc: assert property (@(posedge clk) disable iff (!arst_n)
		vector_ready_q |-> (word_count_q == 9'd0))
		else $error("word count not cleared with vector ready");

	// An empty output register never blocks the request side.
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid_q |-> req_ready)
		else $error("request side stalled with empty output register");

	// Every beat leaving stage one lands in the output register.
	a_advance_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_valid_q)
		else $error("response lost after stage one");

endmodule
`default_nettype wire

/* dv/fwevg_vector_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-weight error vector checker
// Watches the configuration port and both beat channels of the generator,
// keeps its own copy of the registers, vector store and attempt counters,
// computes the response due for every request beat, and compares each
// response beat, field by field, with the oldest one still due.
// ----------------------------------------------------------------------------

module fwevg_vector_checker
	import fwevg_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   req_valid,
	input  wire logic                   req_ready,
	input  wire req_beat_t              req_data,
	input  wire logic                   rsp_valid,
	input  wire logic                   rsp_ready,
	input  wire rsp_beat_t              rsp_data,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	output int unsigned                 mismatches,
	output int unsigned                 outstanding
);

	// Register copies.
	logic [3:0]  cfg_m;
	logic [13:0] cfg_n;
	logic [7:0]  cfg_t;
	logic [8:0]  cfg_tau;

	// Vector store and attempt bookkeeping.
	logic [VEC_WIDTH-1:0] vec_mem [STORE_WORDS];
	int unsigned          taken;
	int unsigned          fed;
	bit                   dup_hit;
	int unsigned          failed_attempts;
	bit                   vec_ready;

	rsp_beat_t   awaited_rsp [$];
	int unsigned fail_count = 0;

	assign mismatches = fail_count;

	// Empties the vector and the per-attempt counts.
	function automatic void wipe_attempt();
		for (int i = 0; i < STORE_WORDS; i++) begin
			vec_mem[i] = '0;
		end
		taken   = 0;
		fed     = 0;
		dup_hit = 1'b0;
	endfunction

	// Works out the response to one request beat and advances the state.
	function automatic rsp_beat_t compute_rsp(input req_beat_t beat);
		rsp_beat_t   rsp;
		int unsigned keep;
		int unsigned pos;
		int unsigned lim;
		int unsigned need;
		int unsigned span;

		rsp.status      = ST_COLLECT;
		rsp.vector_word = '0;
		if (beat.cmd == CMD_READ) begin
			if (vec_ready) begin
				rsp.status = ST_READY;
				if (beat.read_index < STORE_WORDS) begin
					rsp.vector_word = vec_mem[beat.read_index];
				end
			end else if (failed_attempts >= ATTEMPT_LIMIT) begin
				rsp.status = ST_EXHAUST;
			end
		end else begin
			keep = (32'd1 << cfg_m) - 32'd1;
			pos  = {16'd0, beat.rand_word} & keep;
			lim  = {18'd0, cfg_n} & 32'hFFFF_FFF8;
			if (lim > VEC_BITS) begin
				lim = VEC_BITS;
			end
			need = (cfg_t > MAX_WEIGHT) ? MAX_WEIGHT : cfg_t;
			span = (cfg_tau == 0) ? 1 : cfg_tau;

			// A feed after a finished or abandoned generation starts afresh.
			if (vec_ready || failed_attempts >= ATTEMPT_LIMIT) begin
				wipe_attempt();
				failed_attempts = 0;
				vec_ready       = 1'b0;
			end

			if (pos < lim && taken < need) begin
				if (vec_mem[pos >> 6][pos & 63]) begin
					dup_hit = 1'b1;
				end
				vec_mem[pos >> 6][pos & 63] = 1'b1;
				taken++;
			end

			// End of attempt: accept the vector or throw it away.
			fed++;
			if (fed >= span) begin
				if (taken >= need && !dup_hit) begin
					vec_ready  = 1'b1;
					fed        = 0;
					rsp.status = ST_READY;
				end else begin
					wipe_attempt();
					failed_attempts++;
					rsp.status = (failed_attempts >= ATTEMPT_LIMIT) ? ST_EXHAUST : ST_REJECT;
				end
			end
		end
		return rsp;
	endfunction

	// Track register writes, check response beats, queue up due responses.
	always @(posedge clk or negedge arst_n) begin : monitor
		rsp_beat_t want;
		rsp_beat_t due;

		if (!arst_n) begin
			cfg_m           = RST_FIELD_BITS;
			cfg_n           = RST_CODE_LENGTH;
			cfg_t           = RST_ERROR_WEIGHT;
			cfg_tau         = RST_WORDS_PER_ATTEMPT;
			wipe_attempt();
			failed_attempts = 0;
			vec_ready       = 1'b0;
			outstanding    <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FIELD_BITS:        cfg_m   = cfg_data[3:0];
					REG_CODE_LENGTH:       cfg_n   = cfg_data[13:0];
					REG_ERROR_WEIGHT:      cfg_t   = cfg_data[7:0];
					REG_WORDS_PER_ATTEMPT: cfg_tau = cfg_data[8:0];
					default: ;
				endcase
			end

			if (rsp_valid && rsp_ready) begin
				if (awaited_rsp.size() == 0) begin
					fail_count++;
					$display("%0t: response beat with none due: status %0d word %h",
						$time, rsp_data.status, rsp_data.vector_word);
				end else begin
					want = awaited_rsp.pop_front();
					if (rsp_data.status !== want.status) begin
						fail_count++;
						$display("%0t: status expected %0d, got %0d",
							$time, want.status, rsp_data.status);
					end
					if (rsp_data.vector_word !== want.vector_word) begin
						fail_count++;
						$display("%0t: vector word expected %h, got %h",
							$time, want.vector_word, rsp_data.vector_word);
					end
				end
			end

			if (req_valid && req_ready) begin
				due         = compute_rsp(req_data);
				awaited_rsp = {awaited_rsp, due};
			end

			outstanding <= awaited_rsp.size();
		end
	end

endmodule

/* dv/fixed_weight_error_vector_gen_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-weight error vector generator testbench
// Drives request beats in random bursts against a randomly stalling
// receiver, steps the registers through a series of settings between
// phases, and leaves prediction and comparison to the attached checker.
// Directed beats cover range limits, duplicates, empty vectors and the
// largest store index; random phases mix well-formed feeds, raw words and
// reads, and one phase runs the block out of attempts.
// ----------------------------------------------------------------------------

module fixed_weight_error_vector_gen_tb;

	import fwevg_pkg::*;

	localparam int unsigned SETTLE_CYCLES  = 4;
	localparam int unsigned END_PAUSE      = 8;
	localparam int unsigned HOLD_CYCLES    = 150;
	localparam int unsigned WATCHDOG_LIMIT = 2000;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_e;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   req_valid;
	logic                   req_ready;
	req_beat_t              req_data;
	logic                   rsp_valid;
	logic                   rsp_ready;
	rsp_beat_t              rsp_data;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned burst_left = 0;
	int unsigned quiet_cycles = 0;
	logic        hold_ask;

	// Settings currently in the block, used to shape the feed words.
	logic [CFG_DATA_W-1:0] cur_m;
	logic [CFG_DATA_W-1:0] cur_n;

	fixed_weight_error_vector_gen i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	fwevg_vector_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req_data    (req_data),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp_data    (rsp_data),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// 20 ns clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Offers one request beat, opening a new burst after a random gap when the
	// current one is used up, and returns at the edge that accepts the beat.
	task automatic offer(input req_beat_t beat);
		int unsigned gap;

		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_valid <= 1'b1;
		req_data  <= beat;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
	endtask

	task automatic feed(input logic [15:0] word);
		req_beat_t beat;

		beat.cmd        = CMD_FEED;
		beat.rand_word  = word;
		beat.read_index = 7'($urandom_range(0, 127));
		offer(beat);
	endtask

	task automatic read(input logic [6:0] index);
		req_beat_t beat;

		beat.cmd        = CMD_READ;
		beat.rand_word  = 16'($urandom());
		beat.read_index = index;
		offer(beat);
	endtask

	// Stops offering and waits until every due response has come back.
	task automatic quiesce();
		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	// Writes all four registers once the block has gone idle.
	task automatic configure(input logic [CFG_DATA_W-1:0] m, n, t, tau);
		quiesce();
		write_reg(REG_FIELD_BITS, m);
		write_reg(REG_CODE_LENGTH, n);
		write_reg(REG_ERROR_WEIGHT, t);
		write_reg(REG_WORDS_PER_ATTEMPT, tau);
		cfg_we <= 1'b0;
		cur_m   = m;
		cur_n   = n;
	endtask

	// Random phase: reads mixed with feeds. Well-formed feeds walk a cursor
	// through the usable range so that positions rarely repeat within an
	// attempt; the rest are raw random words.
	task automatic run_phase(input int unsigned count, good_pct, read_pct);
		int unsigned keep;
		int unsigned lim;
		int unsigned cursor;
		int unsigned span;
		logic [15:0] word;

		keep = (32'd1 << cur_m[3:0]) - 32'd1;
		lim  = {18'd0, cur_n} & 32'hFFFF_FFF8;
		if (lim > VEC_BITS) begin
			lim = VEC_BITS;
		end
		cursor = (lim == 0) ? 0 : $urandom_range(0, lim - 1);
		span   = (lim < VEC_WIDTH) ? 1 : lim / VEC_WIDTH;
		repeat (count) begin
			if ($urandom_range(0, 99) < read_pct) begin
				if ($urandom_range(0, 9) < 7) begin
					read(7'($urandom_range(0, span - 1)));
				end else begin
					read(7'($urandom_range(0, 127)));
				end
			end else if (lim != 0 && $urandom_range(0, 99) < good_pct) begin
				word   = (16'($urandom()) & ~16'(keep)) | 16'(cursor & keep);
				cursor = (cursor + 1 + $urandom_range(0, 2)) % lim;
				feed(word);
			end else begin
				feed(16'($urandom()));
			end
		end
	endtask

	// Response side: switches at random among open, coin-toss and sparse stall
	// patterns, and holds off completely once, for a long stretch, when asked.
	initial begin : receiver
		rx_mode_e    mode;
		int unsigned mode_left;
		int unsigned hold_left;
		bit          hold_taken;

		mode       = RX_OPEN;
		mode_left  = 0;
		hold_left  = 0;
		hold_taken = 1'b0;
		rsp_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_ask && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_e'($urandom_range(0, 2));
					mode_left = $urandom_range(20, 80);
				end
				mode_left--;
				case (mode)
					RX_OPEN:  rsp_ready <= 1'b1;
					RX_COIN:  rsp_ready <= 1'($urandom_range(0, 1));
					default:  rsp_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Ends the run if no beat moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req_data  <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_FIELD_BITS;
		cfg_data  <= '0;
		hold_ask  <= 1'b0;
		cur_m      = CFG_DATA_W'(RST_FIELD_BITS);
		cur_n      = CFG_DATA_W'(RST_CODE_LENGTH);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Read before anything was generated.
		read(7'd0);

		// Out-of-range word, high bits above m ignored, ready vector, then a
		// feed after ready, a duplicate position and a rejected attempt.
		configure(13, 16, 2, 3);
		feed(16'hFFFF);
		feed(16'hE005);
		feed(16'h000F);
		read(7'd0);
		read(7'd127);
		feed(16'h0003);
		feed(16'h0003);
		feed(16'h0010);
		read(7'd5);

		// Length not a multiple of eight, zero weight and zero words.
		configure(12, 13, 0, 0);
		feed(16'h0000);
		read(7'd0);

		// Length beyond the store, weight above the maximum, widest m.
		configure(15, 16383, 255, 511);
		feed(16'h1FFF);
		feed(16'h2000);
		feed(16'hFFFF);
		read(7'd127);

		// Top bit of the last store word; the write leaves the open attempt
		// alive, so the first feed here closes it with a duplicate.
		configure(13, 8192, 2, 2);
		feed(16'h1FFF);
		feed(16'h1FFF);
		feed(16'h0000);
		read(7'd127);
		read(7'd0);

		// With m of zero every word lands on position zero.
		configure(0, 8, 1, 2);
		feed(16'hABCD);
		feed(16'h1234);
		read(7'd0);

		// Small attempts, with the receiver holding off early on.
		configure(12, 64, 4, 6);
		hold_ask <= 1'b1;
		run_phase(40, 80, 20);

		configure(13, 8192, 32, 34);
		run_phase(45, 90, 10);

		configure(12, 100, 0, 0);
		run_phase(20, 50, 30);

		// Every word misses the range until the attempts run out.
		configure(12, 8, 1, 1);
		repeat (ATTEMPT_LIMIT) feed(16'($urandom()) | 16'h0800);
		read(7'($urandom_range(0, 127)));
		read(7'($urandom_range(0, 127)));
		feed(16'($urandom()) | 16'h0800);
		read(7'($urandom_range(0, 127)));
		run_phase(20, 50, 20);

		configure(12, 2048, 1, 256);
		run_phase(15, 70, 30);

		configure(0, 8, 2, 3);
		run_phase(15, 0, 20);

		configure(13, 1000, 8, 12);
		run_phase(25, 70, 20);

		quiesce();
		repeat (END_PAUSE) @(posedge clk);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
